/* rtl/lif_neuron_step_unit_macros.svh */
// Assertion macros for the LIF neuron step unit.
// Included by files that check their own logic; no other dependencies.
`ifndef LIF_NEURON_STEP_UNIT_MACROS_SVH
`define LIF_NEURON_STEP_UNIT_MACROS_SVH
`ifndef SYNTH
`define LIF_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lif assertion failed");
`define LIF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lif assertion failed");
`else
`define LIF_ASSERT_SAME(label, clk, rstn, ante, cons)
`define LIF_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

/* rtl/lif_pkg.sv */
// Shared types, constants and saturation helper for the LIF neuron step unit.
// No dependencies.
package lif_pkg;

    localparam int VALUE_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int RES_W     = 31;
    localparam int KSTEP_W   = 17;
    localparam int CFG_IDX_W = 3;
    localparam int MUL_A_W   = VALUE_W + 2;
    localparam int MUL_B_W   = VALUE_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int SH_W      = PROD_W - FRAC_BITS;

    localparam logic [KSTEP_W-1:0] K_ONE = KSTEP_W'(1 << FRAC_BITS);

    localparam logic [CFG_IDX_W-1:0] CFG_RESTING_POTENTIAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_POTENTIAL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRE_THRESHOLD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMBRANE_RESISTANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_OVER_TAU       = 3'd4;

    localparam logic MODE_INTEGRATE = 1'b0;
    localparam logic MODE_TICK      = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic signed [VALUE_W-1:0] syn_current;
    } lif_in_t;

    typedef struct packed {
        logic                      fired;
        logic signed [VALUE_W-1:0] membrane_potential;
    } lif_out_t;

    typedef struct packed {
        logic load_in;
        logic prod_load;
        logic mul_sel_step;
        logic diff_load;
        logic tick_commit;
        logic acc_commit;
    } lif_cmd_t;

    function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [SH_W-1:0] x);
        logic [SH_W-VALUE_W:0] hi;
        hi = x[SH_W-1:VALUE_W-1];
        if ((hi == '0) || (hi == '1)) begin
            return x[VALUE_W-1:0];
        end else if (x[SH_W-1]) begin
            return {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(VALUE_W-1){1'b1}}};
        end
    endfunction

endpackage

/* rtl/lif_ctrl.sv */
// Sequencer for the LIF neuron step unit: handshakes and datapath commands.
// Depends on lif_pkg.
module lif_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_mode,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output lif_pkg::lif_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DIFF   = 5'b00010,
        ST_MUL    = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_ACC    = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   accept;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next       = state_reg;
        cmd              = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.prod_load = 1'b1;
                if (accept) begin
                    cmd.load_in = 1'b1;
                    state_next  = (s_mode == lif_pkg::MODE_TICK) ? ST_DIFF : ST_ACC;
                end
            end
            ST_DIFF: begin
                cmd.diff_load = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL: begin
                cmd.prod_load    = 1'b1;
                cmd.mul_sel_step = 1'b1;
                state_next       = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    cmd.tick_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_ACC: begin
                if (out_free) begin
                    cmd.acc_commit = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.tick_commit || cmd.acc_commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/lif_dp.sv */
// Datapath of the LIF neuron step unit: registers, state, shared multiplier.
// Depends on lif_pkg.
module lif_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lif_pkg::lif_cmd_t                   cmd,
    input  lif_pkg::lif_in_t                    s_data,
    input  logic                                cfg_write,
    input  logic [lif_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lif_pkg::VALUE_W-1:0]         cfg_data,
    output lif_pkg::lif_out_t                   m_data
);

    localparam int VW = lif_pkg::VALUE_W;
    localparam int SW = lif_pkg::SH_W;
    localparam int PW = lif_pkg::PROD_W;
    localparam int AW = lif_pkg::MUL_A_W;
    localparam int BW = lif_pkg::MUL_B_W;

    logic signed [VW-1:0]                 rest_reg, vreset_reg, thr_reg;
    logic [lif_pkg::RES_W-1:0]            res_reg;
    logic [lif_pkg::KSTEP_W-1:0]          kstep_reg;
    logic signed [VW-1:0]                 pot_reg, pot_next;
    logic signed [VW-1:0]                 cur_reg, cur_next;
    logic signed [VW-1:0]                 spike_reg;
    logic signed [AW-1:0]                 diff_reg, diff_next;
    logic signed [PW-1:0]                 prod_reg;
    lif_pkg::lif_out_t                    out_reg, out_next;

    logic [lif_pkg::KSTEP_W-1:0]          k_sat;
    logic signed [AW-1:0]                 mul_a;
    logic signed [BW-1:0]                 mul_b;
    logic signed [PW-1:0]                 mul_p;
    logic signed [PW-1:0]                 prod_shift;
    logic signed [SW-1:0]                 prod_sh;
    logic signed [VW-1:0]                 drive;
    logic signed [SW-1:0]                 vsum;
    logic signed [VW-1:0]                 vnew;
    logic signed [SW-1:0]                 acc_sum;
    logic                                 fire;

    assign k_sat = (kstep_reg > lif_pkg::K_ONE) ? lif_pkg::K_ONE : kstep_reg;
    assign mul_a = cmd.mul_sel_step ? diff_reg : AW'(cur_reg);
    assign mul_b = cmd.mul_sel_step ? $signed(BW'(k_sat)) : $signed(BW'(res_reg));
    assign mul_p = mul_a * mul_b;

    assign prod_shift = prod_reg >>> lif_pkg::FRAC_BITS;
    assign prod_sh    = $signed(prod_shift[SW-1:0]);
    assign drive      = lif_pkg::sat_value(prod_sh);
    assign diff_next  = AW'(rest_reg) - AW'(pot_reg) + AW'(drive);
    assign vsum       = SW'(pot_reg) + prod_sh;
    assign vnew       = lif_pkg::sat_value(vsum);
    assign fire       = vnew > thr_reg;
    assign acc_sum    = SW'(cur_reg) + SW'(spike_reg);

    always_comb begin
        pot_next = pot_reg;
        cur_next = cur_reg;
        out_next = out_reg;
        if (cmd.tick_commit) begin
            pot_next                    = fire ? vreset_reg : vnew;
            cur_next                    = '0;
            out_next.fired              = fire;
            out_next.membrane_potential = fire ? vreset_reg : vnew;
        end else if (cmd.acc_commit) begin
            cur_next                    = lif_pkg::sat_value(acc_sum);
            out_next.fired              = 1'b0;
            out_next.membrane_potential = pot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rest_reg   <= '0;
            vreset_reg <= '0;
            thr_reg    <= VW'(1 << lif_pkg::FRAC_BITS);
            res_reg    <= lif_pkg::RES_W'(1 << lif_pkg::FRAC_BITS);
            kstep_reg  <= lif_pkg::KSTEP_W'(6554);
            pot_reg    <= '0;
            cur_reg    <= '0;
        end else begin
            pot_reg <= pot_next;
            cur_reg <= cur_next;
            if (cfg_write) begin
                case (cfg_index)
                    lif_pkg::CFG_RESTING_POTENTIAL:   rest_reg   <= $signed(cfg_data);
                    lif_pkg::CFG_RESET_POTENTIAL:     vreset_reg <= $signed(cfg_data);
                    lif_pkg::CFG_FIRE_THRESHOLD:      thr_reg    <= $signed(cfg_data);
                    lif_pkg::CFG_MEMBRANE_RESISTANCE: res_reg    <= cfg_data[lif_pkg::RES_W-1:0];
                    lif_pkg::CFG_STEP_OVER_TAU:       kstep_reg  <= cfg_data[lif_pkg::KSTEP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            spike_reg <= s_data.syn_current;
        end
        if (cmd.prod_load) begin
            prod_reg <= mul_p;
        end
        if (cmd.diff_load) begin
            diff_reg <= diff_next;
        end
        out_reg <= out_next;
    end

    assign m_data = out_reg;

endmodule

/* rtl/lif_neuron_step_unit.sv */
// Top level of the LIF neuron step unit: sequencer plus datapath.
// Depends on lif_pkg, lif_ctrl, lif_dp and lif_neuron_step_unit_macros.svh.
//
//  channel  dir  handshake            payload
//  s_       in   s_valid / s_ready    lif_in_t  {mode, syn_current}
//  m_       out  m_valid / m_ready    lif_out_t {fired, membrane_potential}
//  cfg_     in   cfg_valid/cfg_ready  cfg_index (3b), cfg_data (32b)
//
// Integrate adds the input to the current; tick runs multiply I*R, form the
// leak difference, multiply by k, update, on the one shared 34x32 multiplier.
// One item in flight; the next is taken while a result waits in the output reg.
// A full output register stalls only the final state, update or accumulate.
// Synchronous active-low reset restores register defaults, potential and current.
// Config writes are always ready; indexes above 4 are dropped.
`include "lif_neuron_step_unit_macros.svh"
module lif_neuron_step_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  lif_pkg::lif_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lif_pkg::lif_out_t             m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lif_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lif_pkg::VALUE_W-1:0]   cfg_data
);

    lif_pkg::lif_cmd_t cmd;
    logic              take_int;
    logic              take_tick;

    assign cfg_ready = 1'b1;

    lif_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_data.mode),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    lif_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_data    (m_data)
    );

    assign take_int  = s_valid && s_ready && !m_valid
                       && (s_data.mode == lif_pkg::MODE_INTEGRATE);
    assign take_tick = s_valid && s_ready && !m_valid
                       && (s_data.mode == lif_pkg::MODE_TICK);

    `LIF_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    `LIF_ASSERT_SAME(a_integrate_latency, aclk, aresetn, take_int, ##2 m_valid)
    `LIF_ASSERT_SAME(a_tick_latency, aclk, aresetn, take_tick, ##4 m_valid)

endmodule
